/* sv/ptam_pkg.sv */
package ptam_pkg;

    // opcodes of an input word
    localparam logic [2:0] OP_HELLO    = 3'd0;
    localparam logic [2:0] OP_REMOVE   = 3'd1;
    localparam logic [2:0] OP_AGE      = 3'd2;
    localparam logic [2:0] OP_QUERY    = 3'd3;
    localparam logic [2:0] OP_RESPONSE = 3'd4;

    // result status codes
    localparam logic [3:0] ST_REFRESHED = 4'd0;
    localparam logic [3:0] ST_INSERTED  = 4'd1;
    localparam logic [3:0] ST_FULL      = 4'd2;
    localparam logic [3:0] ST_REMOVED   = 4'd3;
    localparam logic [3:0] ST_ABSENT    = 4'd4;
    localparam logic [3:0] ST_AGED      = 4'd5;
    localparam logic [3:0] ST_QUERY     = 4'd6;
    localparam logic [3:0] ST_NO_PEERS  = 4'd7;
    localparam logic [3:0] ST_MATCH     = 4'd8;
    localparam logic [3:0] ST_MISMATCH  = 4'd9;
    localparam logic [3:0] ST_UNKNOWN   = 4'd10;

    // silence timeout after reset, in seconds
    localparam logic [15:0] TIMEOUT_RESET = 16'd30;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] peer_address;
        logic [15:0] resp_tid;
        logic [31:0] now_seconds;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] query_address;
        logic [15:0] query_id;
        logic [4:0]  removed_count;
        logic        last_of_run;
    } t_out_word;

    // one table slot as it travels around the ring
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] last_heard;
        logic [15:0] expected_id;
    } t_slot;

    // controls from the sequencer to the step unit
    typedef struct packed {
        logic sweep;
        logic insert_here;
    } t_step_ctl;

    // per-slot findings from the step unit
    typedef struct packed {
        logic hit;
        logic free;
        logic aged;
        logic tid_equal;
    } t_step_flags;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_INSERT,
        S_FINISH
    } t_state;

endpackage

/* sv/ptam_slot_cell.sv */
module ptam_slot_cell
    import ptam_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_rec,
    output t_slot o_rec
);

    logic        r_valid;
    logic [31:0] r_address;
    logic [31:0] r_last_heard;
    logic [15:0] r_expected_id;

    // valid bit, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_rec.valid;
        end
    end

    // slot payload, taken from the neighbor on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_address     <= i_rec.address;
            r_last_heard  <= i_rec.last_heard;
            r_expected_id <= i_rec.expected_id;
        end
    end

    assign o_rec = '{valid: r_valid, address: r_address,
                     last_heard: r_last_heard, expected_id: r_expected_id};

endmodule

/* sv/ptam_step_unit.sv */
module ptam_step_unit
    import ptam_pkg::*;
(
    input  t_slot       i_rec,
    input  t_in_word    i_item,
    input  logic [15:0] i_timeout,
    input  logic [15:0] i_next_id,
    input  t_step_ctl   i_ctl,
    output t_slot       o_rec,
    output t_step_flags o_flags
);

    logic [31:0] w_silence;

    // per-slot compares
    always_comb begin
        w_silence         = i_item.now_seconds - i_rec.last_heard;
        o_flags.hit       = i_rec.valid && (i_rec.address == i_item.peer_address);
        o_flags.free      = !i_rec.valid;
        o_flags.aged      = i_rec.valid && (w_silence > {16'd0, i_timeout});
        o_flags.tid_equal = (i_rec.expected_id == i_item.resp_tid);
    end

    // updated slot handed back into the ring
    always_comb begin
        o_rec = i_rec;
        if (i_ctl.sweep) begin
            case (i_item.opcode)
                OP_HELLO: begin
                    if (o_flags.hit) begin
                        o_rec.last_heard = i_item.now_seconds;
                    end
                end
                OP_REMOVE: begin
                    if (o_flags.hit) begin
                        o_rec.valid = 1'b0;
                    end
                end
                OP_AGE: begin
                    if (o_flags.aged) begin
                        o_rec.valid = 1'b0;
                    end
                end
                OP_QUERY: begin
                    if (i_rec.valid) begin
                        o_rec.expected_id = i_next_id;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_ctl.insert_here) begin
            o_rec.valid       = 1'b1;
            o_rec.address     = i_item.peer_address;
            o_rec.last_heard  = i_item.now_seconds;
            o_rec.expected_id = 16'd0;
        end
    end

endmodule

/* sv/peer_table_aging_tid_match_core.sv */
// channel   | valid       | ready        | word
// ----------+-------------+--------------+------------------------
// input     | i_in_valid  | o_in_ready   | i_in_word  (t_in_word)
// output    | o_out_valid | i_out_ready  | o_out_word (t_out_word)
// config    | i_cfg_valid | o_cfg_ready  | i_cfg_data (timeout)
//
// The table lives in a ring of TABLE_SLOTS cells that rotates one slot per cycle
// past a single step unit, except while a stalled output word holds the sweep. An item
// is swept for one full rotation and then finished before the input is ready again;
// a hello that inserts a new peer takes a second rotation. Each query word comes from one slot.
// Reset (synchronous, active low) clears every slot's valid bit and the id counter
// at once and sets the timeout to 30 s. A stalled output word holds the ring.
module peer_table_aging_tid_match_core
    import ptam_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [SW-1:0] LAST_STEP = SW'(TABLE_SLOTS - 1);

    t_state      r_state, n_state;
    t_in_word    r_item, n_item;
    logic [SW-1:0] r_step, n_step;
    logic        r_found, n_found;
    logic        r_free_seen, n_free_seen;
    logic [SW-1:0] r_free_idx, n_free_idx;
    logic [CW-1:0] r_count, n_count;
    logic        r_mismatch, n_mismatch;
    logic [15:0] r_exp_id, n_exp_id;
    logic [15:0] r_id_counter, n_id_counter;
    logic [15:0] r_timeout;
    logic        r_pend_valid, n_pend_valid;
    logic [31:0] r_pend_addr, n_pend_addr;
    logic [15:0] r_pend_id, n_pend_id;
    logic        r_out_valid, n_out_valid;
    t_out_word   r_out, n_out;

    logic        w_accept;
    logic        w_out_free;
    logic        w_last_step;
    logic        w_sweep;
    logic        w_insert;
    logic        w_finish;
    logic        w_shift;
    logic [15:0] w_next_id;
    logic [CW+4:0] w_count_ext;
    t_step_ctl   w_ctl;
    t_step_flags w_flags;
    t_slot       w_step_rec;
    t_slot       w_ring [TABLE_SLOTS];
    t_out_word   w_final;

    // ring of slot cells, cell 0 feeds the step unit
    for (genvar g = 0; g < TABLE_SLOTS; g++) begin : g_cell
        t_slot w_cell_in;
        if (g == TABLE_SLOTS - 1) begin : g_tail
            assign w_cell_in = w_step_rec;
        end else begin : g_mid
            assign w_cell_in = w_ring[g+1];
        end
        ptam_slot_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_rec   (w_cell_in),
            .o_rec   (w_ring[g])
        );
    end

    ptam_step_unit u_step (
        .i_rec     (w_ring[0]),
        .i_item    (r_item),
        .i_timeout (r_timeout),
        .i_next_id (w_next_id),
        .i_ctl     (w_ctl),
        .o_rec     (w_step_rec),
        .o_flags   (w_flags)
    );

    // handshake helpers
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_last_step = (r_step == LAST_STEP);
    assign w_next_id   = r_id_counter + 16'd1;
    assign w_count_ext = {5'd0, r_count};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_shift && w_last_step) begin
                    if (r_item.opcode == OP_HELLO && !n_found && n_free_seen) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_INSERT: begin
                if (w_last_step) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state decoded controls
    always_comb begin
        o_in_ready = 1'b0;
        w_sweep    = 1'b0;
        w_insert   = 1'b0;
        w_finish   = 1'b0;
        case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_SWEEP:  w_sweep    = 1'b1;
            S_INSERT: w_insert   = 1'b1;
            S_FINISH: w_finish   = 1'b1;
            default: begin
            end
        endcase
        w_shift           = (w_sweep && w_out_free) || w_insert;
        w_ctl.sweep       = w_sweep;
        w_ctl.insert_here = w_insert && (r_step == r_free_idx);
    end

    // closing word of an item
    always_comb begin
        w_final = '{status: ST_UNKNOWN, query_address: r_item.peer_address,
                    query_id: 16'd0, removed_count: 5'd0, last_of_run: 1'b1};
        case (r_item.opcode)
            OP_HELLO: begin
                if (r_found) begin
                    w_final.status = ST_REFRESHED;
                end else if (r_free_seen) begin
                    w_final.status = ST_INSERTED;
                end else begin
                    w_final.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                w_final.status = r_found ? ST_REMOVED : ST_ABSENT;
            end
            OP_AGE: begin
                w_final.status        = ST_AGED;
                w_final.query_address = 32'd0;
                w_final.removed_count = w_count_ext[4:0];
            end
            OP_QUERY: begin
                if (r_pend_valid) begin
                    w_final.status        = ST_QUERY;
                    w_final.query_address = r_pend_addr;
                    w_final.query_id      = r_pend_id;
                end else begin
                    w_final.status        = ST_NO_PEERS;
                    w_final.query_address = 32'd0;
                end
            end
            OP_RESPONSE: begin
                if (!r_found) begin
                    w_final.status = ST_UNKNOWN;
                end else if (r_mismatch) begin
                    w_final.status   = ST_MISMATCH;
                    w_final.query_id = r_exp_id;
                end else begin
                    w_final.status = ST_MATCH;
                end
            end
            default: begin
            end
        endcase
    end

    // sweep bookkeeping and output word
    always_comb begin
        n_item       = r_item;
        n_step       = r_step;
        n_found      = r_found;
        n_free_seen  = r_free_seen;
        n_free_idx   = r_free_idx;
        n_count      = r_count;
        n_mismatch   = r_mismatch;
        n_exp_id     = r_exp_id;
        n_id_counter = r_id_counter;
        n_pend_valid = r_pend_valid;
        n_pend_addr  = r_pend_addr;
        n_pend_id    = r_pend_id;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (w_accept) begin
            n_item       = i_in_word;
            n_step       = '0;
            n_found      = 1'b0;
            n_free_seen  = 1'b0;
            n_free_idx   = '0;
            n_count      = '0;
            n_mismatch   = 1'b0;
            n_exp_id     = 16'd0;
            n_pend_valid = 1'b0;
        end

        if (w_shift) begin
            n_step = w_last_step ? '0 : r_step + 1'b1;
            if (w_sweep) begin
                case (r_item.opcode)
                    OP_HELLO: begin
                        if (w_flags.hit) begin
                            n_found = 1'b1;
                        end
                        if (w_flags.free && !r_free_seen) begin
                            n_free_seen = 1'b1;
                            n_free_idx  = r_step;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_flags.hit) begin
                            n_found = 1'b1;
                        end
                    end
                    OP_AGE: begin
                        if (w_flags.aged) begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    OP_QUERY: begin
                        // hold each query word back until the next one shows up
                        if (w_ring[0].valid) begin
                            if (r_pend_valid) begin
                                n_out_valid = 1'b1;
                                n_out = '{status: ST_QUERY, query_address: r_pend_addr,
                                          query_id: r_pend_id, removed_count: 5'd0,
                                          last_of_run: 1'b0};
                            end
                            n_pend_valid = 1'b1;
                            n_pend_addr  = w_ring[0].address;
                            n_pend_id    = w_next_id;
                            n_id_counter = w_next_id;
                        end
                    end
                    OP_RESPONSE: begin
                        if (w_flags.hit) begin
                            n_found    = 1'b1;
                            n_mismatch = !w_flags.tid_equal;
                            n_exp_id   = w_ring[0].expected_id;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (w_finish && w_out_free) begin
            n_out_valid = 1'b1;
            n_out       = w_final;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_id_counter <= 16'd0;
            r_timeout    <= TIMEOUT_RESET;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_id_counter <= n_id_counter;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // item and sweep payload
    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_step       <= n_step;
        r_found      <= n_found;
        r_free_seen  <= n_free_seen;
        r_free_idx   <= n_free_idx;
        r_count      <= n_count;
        r_mismatch   <= n_mismatch;
        r_exp_id     <= n_exp_id;
        r_pend_valid <= n_pend_valid;
        r_pend_addr  <= n_pend_addr;
        r_pend_id    <= n_pend_id;
        r_out        <= n_out;
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* sv/ptam_checker.sv */
module ptam_checker
    import ptam_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_word   o_out_word
);

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input still ready after accepting a word");

    // a word that is not the last of its item is always a query word
    a_mid_is_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last_of_run) |-> (o_out_word.status == ST_QUERY))
        else $error("non-final word with status other than query");

    // while a run is still open, no new item may enter
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.last_of_run) |-> !o_in_ready)
        else $error("input ready while a query run is open");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("output word changed while stalled");

endmodule

bind peer_table_aging_tid_match_core ptam_checker u_ptam_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
